### hw/rtl/grm_pkg.sv
// Shared types and constants for the grid ray marcher.
// Used by grm_div, grm_sqrt and grid_ray_march; depends on nothing.
package grm_pkg;

  // Position words: signed Q.5 pixels, wide enough for one long step past the grid.
  localparam int POS_W  = 29;
  localparam int CFG_W  = 7;
  localparam int CS_W   = 12;
  localparam int DIR_W  = 16;
  localparam int PROD_W = CS_W + DIR_W;
  localparam int MAG_W  = 28;
  localparam int SQ_W   = 34;
  localparam int LEN_W  = 17;
  localparam int LA_W   = 9;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd16;
  localparam logic [CFG_W-1:0] CS_MIN    = 7'd1;
  localparam logic [CFG_W-1:0] CS_MAX    = 7'd64;
  localparam logic [LEN_W-1:0] LEN_MAX   = 17'h1FFFF;

  // Serial divider geometry.
  localparam int DIV_NW = 29;
  localparam int DIV_DW = 16;
  localparam int DIV_CW = 5;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_CELL_SIZE = 1'b0;

  typedef enum logic {
    CMD_MAP  = 1'b0,
    CMD_CAST = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STOP_WALL  = 2'd0,
    STOP_OUT   = 2'd1,
    STOP_LIMIT = 2'd2
  } stop_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TOP,
    ST_DIVX,
    ST_DIVY,
    ST_RDW,
    ST_MUL,
    ST_CMP,
    ST_DIVS,
    ST_LA,
    ST_LDX,
    ST_LDY,
    ST_LRDW,
    ST_SQ1,
    ST_SQ2,
    ST_SQ3,
    ST_SQW,
    ST_OUT
  } st_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
    logic [DIV_CW-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

endpackage

### hw/rtl/grm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module grm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/grm_div.sv
// Restoring serial divider, one quotient bit per cycle, variable bit count.
// Depends on grm_pkg for the request and response types.
module grm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  grm_pkg::div_req_t req,
  output grm_pkg::div_rsp_t rsp
);

  localparam int NW = grm_pkg::DIV_NW;
  localparam int DW = grm_pkg::DIV_DW;
  localparam int CW = grm_pkg::DIV_CW;
  localparam logic [CW:0] NW_L = (CW + 1)'(NW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [NW-1:0] low_r, low_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   trial;
  logic          ge;

  // The dividend's upper part, below the divisor by contract, seeds the remainder.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    trial    = {rem_r, low_r[NW-1]};
    ge       = trial >= {1'b0, d_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = DW'(req.dividend >> req.nbits);
      low_nxt  = req.dividend << (NW_L - {1'b0, req.nbits});
      q_nxt    = '0;
      cnt_nxt  = req.nbits;
      d_nxt    = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? DW'(trial - {1'b0, d_r}) : DW'(trial);
      q_nxt   = {q_r[NW-2:0], ge};
      low_nxt = {low_r[NW-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;

  // A new request must not land on a division in flight.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider restarted while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a division");

  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0))
    else $error("divider busy with an empty count");

endmodule

### hw/rtl/grm_sqrt.sv
// Integer square root, one result bit per cycle, floor rounding.
// Depends on grm_pkg for the operand and result widths.
module grm_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [grm_pkg::SQ_W-1:0]   value,
  output logic                       done,
  output logic [grm_pkg::LEN_W-1:0]  root
);

  localparam int SW = grm_pkg::SQ_W;
  localparam int RW = SW + 1;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SW-1:0] op_r, op_nxt;
  logic [RW-1:0] res_r, res_nxt;
  logic [RW-1:0] one_r, one_nxt;
  logic [RW-1:0] sum;

  // Classic digit-by-digit root; the trial bit walks down two places a cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    res_nxt  = res_r;
    one_nxt  = one_r;
    sum      = res_r + one_r;
    if (start) begin
      busy_nxt = 1'b1;
      op_nxt   = value;
      res_nxt  = '0;
      one_nxt  = RW'(1) << (SW - 2);
    end else if (busy_r) begin
      if ({1'b0, op_r} >= sum) begin
        op_nxt  = SW'({1'b0, op_r} - sum);
        res_nxt = (res_r >> 1) + one_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      one_nxt = one_r >> 2;
      if (one_r == RW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    res_r <= res_nxt;
    one_r <= one_nxt;
  end

  assign done = done_r;
  assign root = res_r[grm_pkg::LEN_W-1:0];

  // The trial bit is a single bit for the whole of a run.
  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> $onehot(one_r))
    else $error("root trial bit not one-hot");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("root unit restarted while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("root done without a run");

endmodule

### hw/rtl/grid_ray_march.sv
// Grid ray marcher top level: wall map RAM, step sequencer, config register, output stage.
// Depends on grm_pkg, grm_ram, grm_div and grm_sqrt.
//
//  Channel   Direction  Requests carried
//  in_       slave      map writes (no result) and ray casts
//  out_      master     one result per ray cast
//  cfg_      APB slave  cell_size register at byte address 0
//
// A map write goes to the RAM as it is accepted. A ray cast walks the grid cell by cell;
// the shared serial divider gives each cell index, then the cross-axis advance, and the
// root unit gives the length for the output. After reset the map is swept clear, one
// cell a cycle, and no request is taken meanwhile. A finished result waits in the output
// register while the next request is taken; a cast that finishes against a full output
// register holds there.
module grid_ray_march #(
  parameter int MAP_COLS  = 32,
  parameter int MAP_ROWS  = 32,
  parameter int MAX_STEPS = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // tdata: cell_row[4:0], cell_col[9:5], cell_wall[10], ray_id[20:11], origin_x[36:21],
  //        origin_y[52:37], dir_cos[68:53], dir_sin[84:69]
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [87:0]                  in_tdata,
  // tuser: cmd[0]
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // tdata: ray_echo[9:0], ray_length[26:10], hit_x[42:27], hit_y[58:43]
  output logic [63:0]                  out_tdata,
  // tuser: stop_kind[1:0]
  output logic [1:0]                   out_tuser,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [grm_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [grm_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [grm_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  localparam int PW    = grm_pkg::POS_W;
  localparam int NW    = grm_pkg::DIV_NW;
  localparam int DW    = grm_pkg::DIV_DW;
  localparam int CW    = grm_pkg::DIV_CW;
  localparam int CSW   = grm_pkg::CS_W;
  localparam int DRW   = grm_pkg::DIR_W;
  localparam int PRW   = grm_pkg::PROD_W;
  localparam int MW    = grm_pkg::MAG_W;
  localparam int SW    = grm_pkg::SQ_W;
  localparam int LW    = grm_pkg::LEN_W;
  localparam int LAW   = grm_pkg::LA_W;
  localparam int DEPTH = MAP_ROWS * MAP_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CXW   = $clog2(MAP_COLS);
  localparam int CYW   = $clog2(MAP_ROWS);
  localparam int CQ    = $clog2((MAP_COLS > MAP_ROWS) ? MAP_COLS : MAP_ROWS);
  localparam int STW   = $clog2(MAX_STEPS + 1);

  grm_pkg::st_t state_r, state_nxt;

  logic [grm_pkg::CFG_W-1:0] cfg_r, cfg_nxt;
  logic [grm_pkg::CFG_W-1:0] cell_cl;
  logic [CSW-1:0]            cs;
  logic signed [PW-1:0]      lim_x, lim_y;

  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic signed [PW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [15:0]          x0_r, x0_nxt, y0_r, y0_nxt;
  logic signed [DRW-1:0] c_r, c_nxt, s_r, s_nxt;
  logic [DRW-1:0]       ac_r, ac_nxt, as_r, as_nxt;
  logic signed [LAW-1:0] lax_r, lax_nxt, lay_r, lay_nxt;
  logic [9:0]           id_r, id_nxt;
  logic [CXW-1:0]       cx_r, cx_nxt;
  logic [CSW-1:0]       remx_r, remx_nxt;
  logic [CSW-1:0]       dx_r, dx_nxt, dy_r, dy_nxt;
  logic [PRW-1:0]       pa_r, pa_nxt, pb_r, pb_nxt;
  logic                 vert_r, vert_nxt;
  logic [STW-1:0]       steps_r, steps_nxt;
  grm_pkg::stop_t       kind_r, kind_nxt;
  logic [2*MW-1:0]      p1_r, p1_nxt, p2_r, p2_nxt;
  logic [LW-1:0]        len_r, len_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [63:0]          out_data_r, out_data_nxt;
  logic [1:0]           out_user_r, out_user_nxt;

  // Decoded request fields.
  logic [4:0]            f_row, f_col;
  logic                  f_wall;
  logic [9:0]            f_id;
  logic [15:0]           f_ox, f_oy;
  logic signed [DRW-1:0] f_c, f_s;
  logic [DRW-1:0]        f_ac, f_as;
  logic [DRW:0]          f_lax_m, f_lay_m;

  // RAM, divider and root unit hookup.
  logic            ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  grm_pkg::div_req_t div_req;
  grm_pkg::div_rsp_t div_rsp;
  logic            sq_start, sq_done;
  logic [SW-1:0]   sq_value;
  logic [LW-1:0]   sq_root;

  // Step datapath helpers.
  logic signed [PW-1:0] la_x, la_y, q_s, dxs, dys, ex, ey;
  logic [PW-1:0]        ex_a, ey_a;
  logic [2*MW:0]        sq_sum;
  logic                 vert;
  logic [15:0]          hit_x, hit_y;
  logic                 cfg_wr;

  function automatic logic in_grid(input logic signed [PW-1:0] px, input logic signed [PW-1:0] py,
                                   input logic signed [PW-1:0] lx, input logic signed [PW-1:0] ly);
    return !px[PW-1] && !py[PW-1] && (px < lx) && (py < ly);
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [CYW-1:0] cy, input logic [CXW-1:0] cx);
    return AW'(AW'(cy) * AW'(MAP_COLS) + AW'(cx));
  endfunction

  assign f_row  = in_tdata[4:0];
  assign f_col  = in_tdata[9:5];
  assign f_wall = in_tdata[10];
  assign f_id   = in_tdata[20:11];
  assign f_ox   = in_tdata[36:21];
  assign f_oy   = in_tdata[52:37];
  assign f_c    = $signed(in_tdata[68:53]);
  assign f_s    = $signed(in_tdata[84:69]);
  assign f_ac   = f_c[DRW-1] ? DRW'(-f_c) : DRW'(f_c);
  assign f_as   = f_s[DRW-1] ? DRW'(-f_s) : DRW'(f_s);
  // Look-ahead of two pixels, round(64*dir/16384), as a magnitude.
  assign f_lax_m = ({1'b0, f_ac} + (DRW + 1)'(128)) >> 8;
  assign f_lay_m = ({1'b0, f_as} + (DRW + 1)'(128)) >> 8;

  // Cell size in Q.5 and the grid extent.
  always_comb begin
    if (cfg_r < grm_pkg::CS_MIN) begin
      cell_cl = grm_pkg::CS_MIN;
    end else if (cfg_r > grm_pkg::CS_MAX) begin
      cell_cl = grm_pkg::CS_MAX;
    end else begin
      cell_cl = cfg_r;
    end
  end
  assign cs    = {cell_cl, 5'b0};
  assign lim_x = $signed(PW'(cs) * PW'(MAP_COLS));
  assign lim_y = $signed(PW'(cs) * PW'(MAP_ROWS));

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_nxt    = (cfg_wr && (cfg_paddr[2] == grm_pkg::REG_CELL_SIZE)) ?
                      cfg_pwdata[grm_pkg::CFG_W-1:0] : cfg_r;
  assign cfg_prdata = (cfg_paddr[2] == grm_pkg::REG_CELL_SIZE) ?
                      grm_pkg::APB_DW'(cfg_r) : '0;

  // Step arithmetic shared by several states.
  assign la_x = x_r + PW'(lax_r);
  assign la_y = y_r + PW'(lay_r);
  assign q_s  = $signed(PW'(div_rsp.quot));
  assign dxs  = $signed(PW'(dx_r));
  assign dys  = $signed(PW'(dy_r));
  assign vert = (c_r != '0) && ((s_r == '0) || (pa_r < pb_r));
  assign ex   = x_r - $signed(PW'(x0_r));
  assign ey   = y_r - $signed(PW'(y0_r));
  assign ex_a = ex[PW-1] ? PW'(-ex) : PW'(ex);
  assign ey_a = ey[PW-1] ? PW'(-ey) : PW'(ey);
  assign sq_sum = {1'b0, p1_r} + {1'b0, p2_r};

  // Stop point clamped to the output range.
  assign hit_x = x_r[PW-1] ? 16'd0 : ((|x_r[PW-2:16]) ? 16'hFFFF : x_r[15:0]);
  assign hit_y = y_r[PW-1] ? 16'd0 : ((|y_r[PW-2:16]) ? 16'hFFFF : y_r[15:0]);

  // Sequencer: next state, datapath updates and unit requests.
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    x_nxt = x_r;  y_nxt = y_r;  x0_nxt = x0_r;  y0_nxt = y0_r;
    c_nxt = c_r;  s_nxt = s_r;  ac_nxt = ac_r;  as_nxt = as_r;
    lax_nxt = lax_r;  lay_nxt = lay_r;  id_nxt = id_r;
    cx_nxt = cx_r;  remx_nxt = remx_r;  dx_nxt = dx_r;  dy_nxt = dy_r;
    pa_nxt = pa_r;  pb_nxt = pb_r;  vert_nxt = vert_r;  steps_nxt = steps_r;
    kind_nxt = kind_r;  p1_nxt = p1_r;  p2_nxt = p2_r;  len_nxt = len_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    in_tready = (state_r == grm_pkg::ST_IDLE);

    ram_we    = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = 1'b0;
    ram_raddr = cell_addr(CYW'(div_rsp.quot), cx_r);

    div_req.start    = 1'b0;
    div_req.dividend = NW'($unsigned(x_r));
    div_req.divisor  = DW'(cs);
    div_req.nbits    = CW'(CQ);

    sq_start = 1'b0;
    sq_value = sq_sum[SW-1:0];

    unique case (state_r)
      grm_pkg::ST_CLEAR: begin
        ram_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = grm_pkg::ST_IDLE;
        end
      end
      grm_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == grm_pkg::CMD_MAP) begin
            ram_we    = (32'(f_row) < MAP_ROWS) && (32'(f_col) < MAP_COLS);
            ram_waddr = cell_addr(CYW'(f_row), CXW'(f_col));
            ram_wdata = f_wall;
          end else begin
            x_nxt     = $signed(PW'(f_ox));
            y_nxt     = $signed(PW'(f_oy));
            x0_nxt    = f_ox;
            y0_nxt    = f_oy;
            c_nxt     = f_c;
            s_nxt     = f_s;
            ac_nxt    = f_ac;
            as_nxt    = f_as;
            lax_nxt   = f_c[DRW-1] ? -$signed(LAW'(f_lax_m)) : $signed(LAW'(f_lax_m));
            lay_nxt   = f_s[DRW-1] ? -$signed(LAW'(f_lay_m)) : $signed(LAW'(f_lay_m));
            id_nxt    = f_id;
            steps_nxt = '0;
            state_nxt = grm_pkg::ST_TOP;
          end
        end
      end
      grm_pkg::ST_TOP: begin
        if (!in_grid(x_r, y_r, lim_x, lim_y)) begin
          kind_nxt  = grm_pkg::STOP_OUT;
          state_nxt = grm_pkg::ST_SQ1;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = grm_pkg::ST_DIVX;
        end
      end
      grm_pkg::ST_DIVX: begin
        if (div_rsp.done) begin
          cx_nxt           = CXW'(div_rsp.quot);
          remx_nxt         = CSW'(div_rsp.rem);
          div_req.start    = 1'b1;
          div_req.dividend = NW'($unsigned(y_r));
          state_nxt        = grm_pkg::ST_DIVY;
        end
      end
      grm_pkg::ST_DIVY: begin
        // The read address goes out with the row index; data is back next cycle.
        if (div_rsp.done) begin
          // Distance to the boundary ahead on each axis.
          if (!c_r[DRW-1] && (c_r != '0)) begin
            dx_nxt = cs - remx_r;
          end else begin
            dx_nxt = (remx_r == '0) ? cs : remx_r;
          end
          if (!s_r[DRW-1] && (s_r != '0)) begin
            dy_nxt = cs - CSW'(div_rsp.rem);
          end else begin
            dy_nxt = (CSW'(div_rsp.rem) == '0) ? cs : CSW'(div_rsp.rem);
          end
          state_nxt = grm_pkg::ST_RDW;
        end
      end
      grm_pkg::ST_RDW: begin
        priority if (ram_rdata) begin
          kind_nxt  = grm_pkg::STOP_WALL;
          state_nxt = grm_pkg::ST_SQ1;
        end else if (steps_r >= STW'(MAX_STEPS)) begin
          kind_nxt  = grm_pkg::STOP_LIMIT;
          state_nxt = grm_pkg::ST_SQ1;
        end else if ((c_r == '0) && (s_r == '0)) begin
          steps_nxt = steps_r + STW'(1);
          state_nxt = grm_pkg::ST_LA;
        end else begin
          state_nxt = grm_pkg::ST_MUL;
        end
      end
      grm_pkg::ST_MUL: begin
        pa_nxt    = PRW'(dx_r) * PRW'(as_r);
        pb_nxt    = PRW'(dy_r) * PRW'(ac_r);
        state_nxt = grm_pkg::ST_CMP;
      end
      grm_pkg::ST_CMP: begin
        // Move exactly to the chosen boundary; the other axis follows the divider.
        div_req.start = 1'b1;
        div_req.nbits = CW'(NW);
        vert_nxt      = vert;
        steps_nxt     = steps_r + STW'(1);
        if (vert) begin
          div_req.dividend = NW'(pa_r) + NW'(ac_r >> 1);
          div_req.divisor  = ac_r;
          x_nxt = c_r[DRW-1] ? (x_r - dxs) : (x_r + dxs);
        end else begin
          div_req.dividend = NW'(pb_r) + NW'(as_r >> 1);
          div_req.divisor  = as_r;
          y_nxt = s_r[DRW-1] ? (y_r - dys) : (y_r + dys);
        end
        state_nxt = grm_pkg::ST_DIVS;
      end
      grm_pkg::ST_DIVS: begin
        if (div_rsp.done) begin
          if (vert_r) begin
            y_nxt = s_r[DRW-1] ? (y_r - q_s) : (y_r + q_s);
          end else begin
            x_nxt = c_r[DRW-1] ? (x_r - q_s) : (x_r + q_s);
          end
          state_nxt = grm_pkg::ST_LA;
        end
      end
      grm_pkg::ST_LA: begin
        // A look-ahead point off the grid counts as open.
        if (!in_grid(la_x, la_y, lim_x, lim_y)) begin
          state_nxt = grm_pkg::ST_TOP;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = NW'($unsigned(la_x));
          state_nxt        = grm_pkg::ST_LDX;
        end
      end
      grm_pkg::ST_LDX: begin
        if (div_rsp.done) begin
          cx_nxt           = CXW'(div_rsp.quot);
          div_req.start    = 1'b1;
          div_req.dividend = NW'($unsigned(la_y));
          state_nxt        = grm_pkg::ST_LDY;
        end
      end
      grm_pkg::ST_LDY: begin
        if (div_rsp.done) begin
          state_nxt = grm_pkg::ST_LRDW;
        end
      end
      grm_pkg::ST_LRDW: begin
        if (ram_rdata) begin
          kind_nxt  = grm_pkg::STOP_WALL;
          state_nxt = grm_pkg::ST_SQ1;
        end else begin
          state_nxt = grm_pkg::ST_TOP;
        end
      end
      grm_pkg::ST_SQ1: begin
        p1_nxt    = ex_a[MW-1:0] * ex_a[MW-1:0];
        state_nxt = grm_pkg::ST_SQ2;
      end
      grm_pkg::ST_SQ2: begin
        p2_nxt    = ey_a[MW-1:0] * ey_a[MW-1:0];
        state_nxt = grm_pkg::ST_SQ3;
      end
      grm_pkg::ST_SQ3: begin
        // Any square at or above 2^34 has a root past the saturation point.
        if (|sq_sum[2*MW:SW]) begin
          len_nxt   = grm_pkg::LEN_MAX;
          state_nxt = grm_pkg::ST_OUT;
        end else begin
          sq_start  = 1'b1;
          state_nxt = grm_pkg::ST_SQW;
        end
      end
      grm_pkg::ST_SQW: begin
        if (sq_done) begin
          len_nxt   = sq_root;
          state_nxt = grm_pkg::ST_OUT;
        end
      end
      grm_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, hit_y, hit_x, len_r, id_r};
          out_user_nxt  = kind_r;
          state_nxt     = grm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = grm_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= grm_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      cfg_r       <= grm_pkg::CFG_RESET;
      out_valid_r <= 1'b0;
      steps_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
      steps_r     <= steps_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    x_r <= x_nxt;  y_r <= y_nxt;  x0_r <= x0_nxt;  y0_r <= y0_nxt;
    c_r <= c_nxt;  s_r <= s_nxt;  ac_r <= ac_nxt;  as_r <= as_nxt;
    lax_r <= lax_nxt;  lay_r <= lay_nxt;  id_r <= id_nxt;
    cx_r <= cx_nxt;  remx_r <= remx_nxt;  dx_r <= dx_nxt;  dy_r <= dy_nxt;
    pa_r <= pa_nxt;  pb_r <= pb_nxt;  vert_r <= vert_nxt;
    kind_r <= kind_nxt;  p1_r <= p1_nxt;  p2_r <= p2_nxt;  len_r <= len_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  grm_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  grm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  grm_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (sq_value),
    .done  (sq_done),
    .root  (sq_root)
  );

  // A divider answer only ever arrives while the sequencer waits for one.
  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> ((state_r == grm_pkg::ST_DIVX) || (state_r == grm_pkg::ST_DIVY) ||
                      (state_r == grm_pkg::ST_DIVS) || (state_r == grm_pkg::ST_LDX) ||
                      (state_r == grm_pkg::ST_LDY)))
    else $error("divider answer outside a wait state");

  // The map is written only by the clearing sweep or an accepted map request.
  a_map_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == grm_pkg::ST_CLEAR) || (in_tvalid && in_tready)))
    else $error("map written during a cast");

  // The step count never passes the limit.
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= STW'(MAX_STEPS))
    else $error("step count beyond limit");

  // A result is loaded only when the output register has room.
  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_data_r == $past(out_data_r)))
    else $error("pending result overwritten");

endmodule
